@@ sv/avr_pkg.sv @@
package avr_pkg;

    // Default CORDIC depth and the hard limit on it
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int MAX_STAGES        = 32;

    // Angle constants in Q2.30
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    // Sideband carried alongside the axis and angle datapaths
    typedef struct packed {
        logic [2:0][31:0] vec;
        logic [2:0]       sgn;
        logic             pass;
        logic             zflag;
        logic [2:0][31:0] mag;
    } t_side;

    // atan(2^-i) in Q2.30, rounded
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd843314857;
            1:  v = 32'd497837829;
            2:  v = 32'd263043837;
            3:  v = 32'd133525159;
            4:  v = 32'd67021687;
            5:  v = 32'd33543516;
            6:  v = 32'd16775851;
            7:  v = 32'd8388437;
            8:  v = 32'd4194283;
            9:  v = 32'd2097149;
            10: v = 32'd1048576;
            11: v = 32'd524288;
            12: v = 32'd262144;
            13: v = 32'd131072;
            14: v = 32'd65536;
            15: v = 32'd32768;
            16: v = 32'd16384;
            17: v = 32'd8192;
            18: v = 32'd4096;
            19: v = 32'd2048;
            20: v = 32'd1024;
            21: v = 32'd512;
            22: v = 32'd256;
            23: v = 32'd128;
            24: v = 32'd64;
            25: v = 32'd32;
            26: v = 32'd16;
            27: v = 32'd8;
            28: v = 32'd4;
            29: v = 32'd2;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Q2.30 product rounding: floor((p + 2^29) / 2^30)
    function automatic logic signed [35:0] mul_rnd(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd536870912;
        return t[65:30];
    endfunction

endpackage

@@ sv/avr_sqrt_cell.sv @@
module avr_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_op,
    input  logic [63:0] i_res,
    output logic [63:0] o_op,
    output logic [63:0] o_res
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic [63:0] trial;
    logic [63:0] r_op;
    logic [63:0] r_res;

    assign trial = i_res + BIT;

    // One result bit per cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_op >= trial) begin
                r_op  <= i_op - trial;
                r_res <= (i_res >> 1) + BIT;
            end else begin
                r_op  <= i_op;
                r_res <= i_res >> 1;
            end
        end
    end

    assign o_op  = r_op;
    assign o_res = r_res;

endmodule

@@ sv/avr_div_cell.sv @@
module avr_div_cell #(
    parameter int POS = 30
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [61:0] i_rem,
    input  logic [31:0] i_den,
    input  logic [30:0] i_quo,
    output logic [61:0] o_rem,
    output logic [31:0] o_den,
    output logic [30:0] o_quo
);

    logic [62:0] sub;
    logic [62:0] diff;
    logic [61:0] r_rem;
    logic [31:0] r_den;
    logic [30:0] r_quo;

    assign sub  = 63'(i_den) << POS;
    assign diff = {1'b0, i_rem} - sub;

    // Restoring step, one quotient bit per cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= i_den;
            if ({1'b0, i_rem} >= sub) begin
                r_rem <= diff[61:0];
                r_quo <= i_quo | (31'd1 << POS);
            end else begin
                r_rem <= i_rem;
                r_quo <= i_quo;
            end
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

@@ sv/avr_cordic_cell.sv @@
module avr_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [33:0] i_x,
    input  logic signed [33:0] i_y,
    input  logic signed [33:0] i_z,
    output logic signed [33:0] o_x,
    output logic signed [33:0] o_y,
    output logic signed [33:0] o_z
);

    localparam logic signed [33:0] ATAN = $signed({2'b00, avr_pkg::atan_q30(STAGE)});

    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;

    assign dx = i_y >>> STAGE;
    assign dy = i_x >>> STAGE;

    // Micro-rotation towards z = 0
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_z >= 0) begin
                r_x <= i_x - dx;
                r_y <= i_y + dy;
                r_z <= i_z - ATAN;
            end else begin
                r_x <= i_x + dx;
                r_y <= i_y - dy;
                r_z <= i_z + ATAN;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

@@ sv/axis_angle_vector_rotate.sv @@
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_vec_x/y/z, i_axis_x/y/z, i_turn_angle
// output    out        o_valid / i_ready    o_rot_x/y/z, o_zero_axis
//
// One item per cycle sustained while no output stall has filled the skid register.
// The pipeline depth is set by the 32-cell square root and the 31-cell divider chains;
// the CORDIC row runs alongside them and is padded to the same depth.
// Synchronous active-low reset clears the stage valids and the output and skid valid flags.
// An output stall fills a one-item skid register; the whole row then holds.
module axis_angle_vector_rotate #(
    parameter int CORDIC_STAGES = avr_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_vec_x,
    input  logic [31:0] i_vec_y,
    input  logic [31:0] i_vec_z,
    input  logic [31:0] i_axis_x,
    input  logic [31:0] i_axis_y,
    input  logic [31:0] i_axis_z,
    input  logic [31:0] i_turn_angle,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_rot_x,
    output logic [31:0] o_rot_y,
    output logic [31:0] o_rot_z,
    output logic        o_zero_axis
);

    localparam int N    = (CORDIC_STAGES > avr_pkg::MAX_STAGES) ?
                          avr_pkg::MAX_STAGES : CORDIC_STAGES;
    localparam int LAST = 74;
    localparam int CSD  = 67 - N;

    logic en;

    logic [LAST:0]    r_vld;
    logic [2:0][31:0] r_vec;
    logic [2:0][31:0] r_axis;
    logic [31:0]      r_ang;

    avr_pkg::t_side r_side [1:LAST-1];
    avr_pkg::t_side n_side1;
    avr_pkg::t_side n_side2;

    // Output stage and skid
    logic             r_o_v;
    logic             r_sk_v;
    logic [2:0][31:0] r_o_rot;
    logic             r_o_zf;
    logic [2:0][31:0] r_sk_rot;
    logic             r_sk_zf;

    assign en      = !r_sk_v;
    assign o_ready = en;

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_valid};
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vec  <= {i_vec_z, i_vec_y, i_vec_x};
            r_axis <= {i_axis_z, i_axis_y, i_axis_x};
            r_ang  <= i_turn_angle;
        end
    end

    // Stage 1: magnitudes and special-case flags
    always_comb begin
        logic [32:0] neg_a;
        n_side1 = '0;
        n_side1.vec   = r_vec;
        n_side1.zflag = (r_ang != 32'd0);
        n_side1.pass  = (r_ang == 32'd0) || (r_axis == '0);
        for (int i = 0; i < 3; i++) begin
            neg_a = 33'd0 - {r_axis[i][31], r_axis[i]};
            n_side1.sgn[i] = r_axis[i][31];
            n_side1.mag[i] = r_axis[i][31] ? neg_a[31:0] : r_axis[i];
        end
    end

    // Stage 2: common shift so the largest magnitude lies in [2^30, 2^31]
    always_comb begin
        logic [31:0] orv;
        logic [4:0]  msb;
        logic [4:0]  sh;
        orv = r_side[1].mag[0] | r_side[1].mag[1] | r_side[1].mag[2];
        msb = '0;
        for (int i = 0; i < 32; i++) begin
            if (orv[i]) begin
                msb = 5'(i);
            end
        end
        sh = (msb == 5'd31) ? 5'd0 : 5'd30 - msb;
        n_side2 = r_side[1];
        for (int i = 0; i < 3; i++) begin
            n_side2.mag[i] = r_side[1].mag[i] << sh;
        end
    end

    // Sideband line
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[1] <= n_side1;
            r_side[2] <= n_side2;
            for (int k = 3; k < LAST; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Stages 3 and 4: sum of squares
    logic [2:0][63:0] r_sq;
    logic [63:0]      r_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_side[2].mag[i] * r_side[2].mag[i];
            end
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    // Stages 5..36: square root row
    logic [63:0] w_op  [0:32];
    logic [63:0] w_res [0:32];

    assign w_op[0]  = r_sum;
    assign w_res[0] = '0;

    for (genvar j = 0; j < 32; j++) begin : g_sqrt
        avr_sqrt_cell #(.STEP(j)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_op  (w_op[j]),
            .i_res (w_res[j]),
            .o_op  (w_op[j+1]),
            .o_res (w_res[j+1])
        );
    end

    // Stage 37: rounded dividends
    logic [61:0] r_rem [0:2];
    logic [31:0] r_den;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= w_res[32][31:0];
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= {r_side[36].mag[i], 30'd0} + 62'(w_res[32][31:1]);
            end
        end
    end

    // Stages 38..68: divider rows, one lane per axis component
    logic [61:0] d_rem [0:31][0:2];
    logic [31:0] d_den [0:31][0:2];
    logic [30:0] d_quo [0:31][0:2];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign d_rem[0][l] = r_rem[l];
        assign d_den[0][l] = r_den;
        assign d_quo[0][l] = '0;
        for (genvar k = 0; k < 31; k++) begin : g_div
            avr_div_cell #(.POS(30 - k)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_rem (d_rem[k][l]),
                .i_den (d_den[k][l]),
                .i_quo (d_quo[k][l]),
                .o_rem (d_rem[k+1][l]),
                .o_den (d_den[k+1][l]),
                .o_quo (d_quo[k+1][l])
            );
        end
    end

    // Stage 69: signed unit axis
    logic signed [31:0] r_u [0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= r_side[68].sgn[i] ? -$signed({1'b0, d_quo[31][i]}) :
                                               $signed({1'b0, d_quo[31][i]});
            end
        end
    end

    // Angle stages 1 and 2: wrap into [-pi, pi], then fold into [-pi/2, pi/2]
    logic signed [35:0] r_z1;
    logic signed [33:0] r_z2;
    logic               r_neg2;

    always_ff @(posedge i_clk) begin
        logic signed [35:0] za;
        logic signed [35:0] zb;
        logic signed [35:0] zc;
        logic               ng;
        za = $signed({{2{r_ang[31]}}, r_ang, 2'b00});
        if (za > avr_pkg::PI_Q30) begin
            za = za - avr_pkg::TWO_PI_Q30;
        end
        zb = (za < -avr_pkg::PI_Q30) ? za + avr_pkg::TWO_PI_Q30 : za;
        ng = 1'b0;
        zc = r_z1;
        if (r_z1 > avr_pkg::HALF_PI_Q30) begin
            zc = r_z1 - avr_pkg::PI_Q30;
            ng = 1'b1;
        end else if (r_z1 < -avr_pkg::HALF_PI_Q30) begin
            zc = r_z1 + avr_pkg::PI_Q30;
            ng = 1'b1;
        end
        if (en) begin
            r_z1   <= zb;
            r_z2   <= zc[33:0];
            r_neg2 <= ng;
        end
    end

    // CORDIC row
    logic signed [33:0] c_x [0:N];
    logic signed [33:0] c_y [0:N];
    logic signed [33:0] c_z [0:N];
    logic               r_negd [0:N-1];

    assign c_x[0] = avr_pkg::GAIN_Q30;
    assign c_y[0] = '0;
    assign c_z[0] = r_z2;

    for (genvar i = 0; i < N; i++) begin : g_cordic
        avr_cordic_cell #(.STAGE(i)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (c_x[i]),
            .i_y   (c_y[i]),
            .i_z   (c_z[i]),
            .o_x   (c_x[i+1]),
            .o_y   (c_y[i+1]),
            .o_z   (c_z[i+1])
        );
    end

    // Fold flag follows the CORDIC row; cos/sin then padded to stage 69
    logic signed [31:0] r_c [0:CSD-1];
    logic signed [31:0] r_s [0:CSD-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_negd[0] <= r_neg2;
            for (int i = 1; i < N; i++) begin
                r_negd[i] <= r_negd[i-1];
            end
            r_c[0] <= r_negd[N-1] ? 32'(-c_x[N]) : c_x[N][31:0];
            r_s[0] <= r_negd[N-1] ? 32'(-c_y[N]) : c_y[N][31:0];
            for (int i = 1; i < CSD; i++) begin
                r_c[i] <= r_c[i-1];
                r_s[i] <= r_s[i-1];
            end
        end
    end

    // Stage 70: u_i*u_j, u_k*s and 1-c
    logic signed [31:0] r_uu [0:5];
    logic signed [31:0] r_us1 [0:2];
    logic signed [32:0] r_t1;
    logic signed [31:0] r_c1;

    always_ff @(posedge i_clk) begin
        logic signed [63:0] p;
        logic signed [35:0] q;
        logic [1:0]         ia [0:5];
        logic [1:0]         ib [0:5];
        ia[0] = 2'd0; ib[0] = 2'd0;
        ia[1] = 2'd1; ib[1] = 2'd1;
        ia[2] = 2'd2; ib[2] = 2'd2;
        ia[3] = 2'd0; ib[3] = 2'd1;
        ia[4] = 2'd0; ib[4] = 2'd2;
        ia[5] = 2'd1; ib[5] = 2'd2;
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                p = r_u[ia[i]] * r_u[ib[i]];
                q = avr_pkg::mul_rnd({{2{p[63]}}, p});
                r_uu[i] <= q[31:0];
            end
            for (int i = 0; i < 3; i++) begin
                p = r_u[i] * r_s[CSD-1];
                q = avr_pkg::mul_rnd({{2{p[63]}}, p});
                r_us1[i] <= q[31:0];
            end
            r_t1 <= 33'sd1073741824 - {r_c[CSD-1][31], r_c[CSD-1]};
            r_c1 <= r_c[CSD-1];
        end
    end

    // Stage 71: scale by 1-c
    logic signed [32:0] r_ww [0:5];
    logic signed [31:0] r_us2 [0:2];
    logic signed [31:0] r_c2;

    always_ff @(posedge i_clk) begin
        logic signed [64:0] p;
        logic signed [35:0] q;
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                p = r_uu[i] * r_t1;
                q = avr_pkg::mul_rnd({p[64], p});
                r_ww[i] <= q[32:0];
            end
            r_us2 <= r_us1;
            r_c2  <= r_c1;
        end
    end

    // Stage 72: matrix entries, clamped to [-1, 1]
    function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd1073741824) begin
            r = 32'sd1073741824;
        end else if (v < -34'sd1073741824) begin
            r = -32'sd1073741824;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic signed [31:0] r_m [0:2][0:2];

    always_ff @(posedge i_clk) begin
        logic signed [33:0] w [0:5];
        logic signed [33:0] s [0:2];
        logic signed [33:0] c;
        for (int i = 0; i < 6; i++) begin
            w[i] = 34'(r_ww[i]);
        end
        for (int i = 0; i < 3; i++) begin
            s[i] = 34'(r_us2[i]);
        end
        c = 34'(r_c2);
        if (en) begin
            r_m[0][0] <= clamp_one(w[0] + c);
            r_m[0][1] <= clamp_one(w[3] - s[2]);
            r_m[0][2] <= clamp_one(w[4] + s[1]);
            r_m[1][0] <= clamp_one(w[3] + s[2]);
            r_m[1][1] <= clamp_one(w[1] + c);
            r_m[1][2] <= clamp_one(w[5] - s[0]);
            r_m[2][0] <= clamp_one(w[4] - s[1]);
            r_m[2][1] <= clamp_one(w[5] + s[0]);
            r_m[2][2] <= clamp_one(w[2] + c);
        end
    end

    // Stage 73: entry times vector coordinate
    logic signed [63:0] r_p [0:2][0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= r_m[i][j] * $signed(r_side[72].vec[j]);
                end
            end
        end
    end

    // Stage 74: row sums, rounding, saturation and pass-through
    logic [2:0][31:0] r_res;
    logic             r_zf;

    always_ff @(posedge i_clk) begin
        logic signed [65:0] acc;
        logic signed [35:0] hi;
        logic [2:0][31:0]   res;
        for (int i = 0; i < 3; i++) begin
            acc = 66'sd536870912 + 66'(r_p[i][0]) + 66'(r_p[i][1]) + 66'(r_p[i][2]);
            hi  = acc[65:30];
            if (hi > 36'sd2147483647) begin
                res[i] = 32'h7fff_ffff;
            end else if (hi < -36'sd2147483648) begin
                res[i] = 32'h8000_0000;
            end else begin
                res[i] = hi[31:0];
            end
        end
        if (en) begin
            if (r_side[73].pass) begin
                r_res <= r_side[73].vec;
                r_zf  <= r_side[73].zflag;
            end else begin
                r_res <= res;
                r_zf  <= 1'b0;
            end
        end
    end

    // Output register with one-item skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (i_ready) begin
                r_sk_v <= 1'b0;
            end
        end else if (r_vld[LAST]) begin
            if (!r_o_v || i_ready) begin
                r_o_v <= 1'b1;
            end else begin
                r_sk_v <= 1'b1;
            end
        end else if (i_ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (i_ready) begin
                r_o_rot <= r_sk_rot;
                r_o_zf  <= r_sk_zf;
            end
        end else if (r_vld[LAST]) begin
            if (!r_o_v || i_ready) begin
                r_o_rot <= r_res;
                r_o_zf  <= r_zf;
            end else begin
                r_sk_rot <= r_res;
                r_sk_zf  <= r_zf;
            end
        end
    end

    assign o_valid     = r_o_v;
    assign o_rot_x     = r_o_rot[0];
    assign o_rot_y     = r_o_rot[1];
    assign o_rot_z     = r_o_rot[2];
    assign o_zero_axis = r_o_zf;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_o_v)
        else $error("skid holds an item while the output stage is empty");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[LAST] && r_o_v && !i_ready) |=> r_sk_v)
        else $error("finished item lost on output stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted item missing from first stage");

    a_skid_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |=> $stable(r_vld) || !$past(r_sk_v))
        else $error("row advanced while skid full");
`endif

endmodule

@@ dv/axis_angle_vector_rotate_tb.sv @@
module axis_angle_vector_rotate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES    = avr_pkg::CORDIC_STAGES_DEF;
    localparam int LATENCY   = 75;
    localparam int CYC_LIMIT = 400000;

    localparam longint ONE_Q30  = 64'sd1073741824;
    localparam longint HALF_Q30 = 64'sd536870912;
    localparam longint PI_Q30   = 64'sd3373259426;
    localparam longint HPI_Q30  = 64'sd1686629713;
    localparam longint TPI_Q30  = 64'sd6746518852;
    localparam longint GAIN_Q30 = 64'sd652032874;

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic        zflag;
    } t_rot;

    typedef struct {
        logic [31:0] v[3];
        logic [31:0] a[3];
        logic [31:0] ang;
    } t_vec_item;

    // Arithmetic-shift, rounded-multiply and clamping helpers
    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint mulq(longint a, longint b);
        return (a * b + HALF_Q30) >>> 30;
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > ONE_Q30) return ONE_Q30;
        if (v < -ONE_Q30) return -ONE_Q30;
        return v;
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic longint unsigned isqrt(longint unsigned op);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > op) bitv >>= 2;
        while (bitv != 0) begin
            if (op >= res + bitv) begin
                op -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Expected rotation of one item
    function automatic t_rot rotate_vec(t_vec_item it);
        t_rot r;
        longint v[3], a[3], u[3], m[3][3];
        longint unsigned mag[3], mx, sum, nrm;
        longint c, s, t, z, x, y, dx, dy, acc, ang;
        int sh, n;
        bit neg;
        mx = 0;
        sum = 0;
        sh = 0;
        neg = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = longint'($signed(it.v[i]));
            a[i] = longint'($signed(it.a[i]));
            mag[i] = (a[i] < 0) ? -a[i] : a[i];
            if (mag[i] > mx) mx = mag[i];
        end
        ang = longint'($signed(it.ang));
        if (ang == 0 || mx == 0) begin
            r.rx = it.v[0];
            r.ry = it.v[1];
            r.rz = it.v[2];
            r.zflag = (ang != 0);
            return r;
        end
        while (mx < (64'd1 << 30)) begin
            mx <<= 1;
            sh++;
        end
        for (int i = 0; i < 3; i++) begin
            mag[i] <<= sh;
            sum += mag[i] * mag[i];
        end
        nrm = isqrt(sum);
        for (int i = 0; i < 3; i++) begin
            longint q;
            q = longint'(((mag[i] << 30) + (nrm >> 1)) / nrm);
            u[i] = (a[i] < 0) ? -q : q;
        end
        // Angle folding and CORDIC
        z = ang * 4;
        x = GAIN_Q30;
        y = 0;
        if (z > PI_Q30) z -= TPI_Q30;
        if (z < -PI_Q30) z += TPI_Q30;
        if (z > HPI_Q30) begin
            z -= PI_Q30;
            neg = 1;
        end else if (z < -HPI_Q30) begin
            z += PI_Q30;
            neg = 1;
        end
        n = (STAGES > 32) ? 32 : STAGES;
        for (int i = 0; i < n; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(avr_pkg::atan_q30(i));
            end else begin
                x += dx;
                y -= dy;
                z += longint'(avr_pkg::atan_q30(i));
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
        t = ONE_Q30 - c;
        m[0][0] = mulq(mulq(u[0], u[0]), t) + c;
        m[0][1] = mulq(mulq(u[0], u[1]), t) - mulq(u[2], s);
        m[0][2] = mulq(mulq(u[2], u[0]), t) + mulq(u[1], s);
        m[1][0] = mulq(mulq(u[0], u[1]), t) + mulq(u[2], s);
        m[1][1] = mulq(mulq(u[1], u[1]), t) + c;
        m[1][2] = mulq(mulq(u[1], u[2]), t) - mulq(u[0], s);
        m[2][0] = mulq(mulq(u[0], u[2]), t) - mulq(u[1], s);
        m[2][1] = mulq(mulq(u[1], u[2]), t) + mulq(u[0], s);
        m[2][2] = mulq(mulq(u[2], u[2]), t) + c;
        for (int i = 0; i < 3; i++) begin
            acc = HALF_Q30;
            for (int j = 0; j < 3; j++) acc += clamp_one(m[i][j]) * v[j];
            case (i)
                0: r.rx = sat32(acc >>> 30);
                1: r.ry = sat32(acc >>> 30);
                default: r.rz = sat32(acc >>> 30);
            endcase
        end
        r.zflag = 1'b0;
        return r;
    endfunction

    // Scoreboard of expected rotations
    class rot_scoreboard;
        t_rot pending[$];
        int   n_err;

        function new();
            n_err = 0;
        endfunction

        function void note_item(t_vec_item it);
            pending.push_back(rotate_vec(it));
        endfunction

        function void check_rot(t_rot got);
            t_rot exp_r;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch: exp x=%h y=%h z=%h zf=%b got x=%h y=%h z=%h zf=%b",
                             exp_r.rx, exp_r.ry, exp_r.rz, exp_r.zflag,
                             got.rx, got.ry, got.rz, got.zflag);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_vec_x, i_vec_y, i_vec_z;
    logic [31:0] i_axis_x, i_axis_y, i_axis_z;
    logic [31:0] i_turn_angle;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_rot_x, o_rot_y, o_rot_z;
    logic        o_zero_axis;

    rot_scoreboard sb;
    int  send_idle;
    int  recv_stall;
    int  cycles;

    axis_angle_vector_rotate #(.CORDIC_STAGES(STAGES)) u_dut (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Cycle guard
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYC_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Result monitor and receiver stalls
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_rot(t_rot'{o_rot_x, o_rot_y, o_rot_z, o_zero_axis});
            @(negedge i_clk);
            i_ready = ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return $urandom_range(8) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return $urandom_range(2000) - 1000;
            4: return {{3{1'b0}}, 29'($urandom)} - 32'h1000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Drive one item, holding it until accepted; valid stays up for a following item
    task automatic send_item(t_vec_item it);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_vec_x      <= it.v[0];
        i_vec_y      <= it.v[1];
        i_vec_z      <= it.v[2];
        i_axis_x     <= it.a[0];
        i_axis_y     <= it.a[1];
        i_axis_z     <= it.a[2];
        i_turn_angle <= it.ang;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic send_rand();
        t_vec_item it;
        for (int i = 0; i < 3; i++) begin
            it.v[i] = rand_word();
            it.a[i] = ($urandom_range(15) == 0) ? 32'd0 : rand_word();
        end
        it.ang = rand_angle();
        send_item(it);
    endtask

    task automatic send_fixed(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                              logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                              logic [31:0] an);
        t_vec_item it;
        it.v = '{vx, vy, vz};
        it.a = '{ax, ay, az};
        it.ang = an;
        send_item(it);
    endtask

    initial begin
        sb = new();
        send_idle = 0;
        recv_stall = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        {i_vec_x, i_vec_y, i_vec_z} = '0;
        {i_axis_x, i_axis_y, i_axis_z, i_turn_angle} = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero angle, zero axis, extremes, folds, overflow
        send_fixed(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0, 0);
        send_fixed(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0, 32'h1000_0000);
        send_fixed(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 32'h1921_fb54);
        send_fixed(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 32'h3243_f6a9);
        send_fixed(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 32'hcdbc_0957);
        send_fixed(32'h0001_0000, 32'h0001_0000, 0, 1, 1, 1, 32'h7fff_ffff);
        send_fixed(32'h0001_0000, 32'h0001_0000, 0, 1, 1, 1, 32'h8000_0000);
        send_fixed(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0800_0000);
        send_fixed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 0, 32'h8000_0000, 32'hf800_0000);
        send_fixed(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   1, 0, 0, 32'h0000_0001);
        send_fixed(32'hffff_ffff, 1, 32'h0000_8000, 0, 32'hffff_ffff, 0, 32'h2000_0000);
        send_fixed(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h3000_0000);

        // Random phases with several idling mixes
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 77; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 77; end
                3: begin send_idle = 26; recv_stall = 26; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            repeat (190) send_rand();
        end
        i_valid <= 1'b0;

        // Drain
        recv_stall = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.n_err == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
sv/avr_pkg.sv
sv/avr_sqrt_cell.sv
sv/avr_div_cell.sv
sv/avr_cordic_cell.sv
sv/axis_angle_vector_rotate.sv
dv/axis_angle_vector_rotate_tb.sv
